// ----- design/hlcl_pkg.sv -----
package hlcl_pkg;

	localparam int IN_W    = 8;
	localparam int OUT_W   = 16;
	localparam int ALPHA_W = 6;

	localparam logic [IN_W-1:0] NEWLINE_BYTE = 8'd10;
	localparam logic [IN_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [IN_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [IN_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [IN_W-1:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [ALPHA_W-1:0] UPPER_BASE = 6'd0;
	localparam logic [ALPHA_W-1:0] LOWER_BASE = 6'd26;
	localparam logic [OUT_W-1:0] TOTAL_MAX = 16'hFFFF;

	// sequencer steps
	typedef enum logic [3:0] {
		U_IDLE,
		U_GRD,
		U_GWR,
		U_TEST,
		U_SCLR,
		U_SRD,
		U_SCMP,
		U_RRD,
		U_RWR,
		U_PUSH,
		U_DONE,
		U_CLR
	} step_t;

	// read port selection
	typedef enum logic [1:0] {
		RD_NONE,
		RD_CNT,
		RD_MW_SI,
		RD_MW_LAST
	} rd_t;

	// weight store write selection
	typedef enum logic [1:0] {
		WR_NONE,
		WR_GATHER,
		WR_BEST,
		WR_PUSH
	} wr_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NOT_GO,
		C_GI_MORE,
		C_LEN_LE1,
		C_SI_MORE,
		C_PICK_FIRST,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		rd_t   rd;
		wr_t   wr;
		logic  init;
		logic  si_clr;
		logic  scan;
		logic  emit;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// control store
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t c;
		c.rd     = RD_NONE;
		c.wr     = WR_NONE;
		c.init   = 1'b0;
		c.si_clr = 1'b0;
		c.scan   = 1'b0;
		c.emit   = 1'b0;
		c.cond   = C_NEXT;
		c.target = U_IDLE;
		case (step)
			U_IDLE: begin
				c.init   = 1'b1;
				c.cond   = C_NOT_GO;
				c.target = U_IDLE;
			end
			U_GRD: begin
				c.rd = RD_CNT;
			end
			U_GWR: begin
				c.wr     = WR_GATHER;
				c.cond   = C_GI_MORE;
				c.target = U_GRD;
			end
			U_TEST: begin
				c.cond   = C_LEN_LE1;
				c.target = U_DONE;
			end
			U_SCLR: begin
				c.si_clr = 1'b1;
			end
			U_SRD: begin
				c.rd = RD_MW_SI;
			end
			U_SCMP: begin
				c.scan   = 1'b1;
				c.cond   = C_SI_MORE;
				c.target = U_SRD;
			end
			U_RRD: begin
				c.rd = RD_MW_LAST;
			end
			U_RWR: begin
				c.wr     = WR_BEST;
				c.cond   = C_PICK_FIRST;
				c.target = U_SCLR;
			end
			U_PUSH: begin
				c.wr     = WR_PUSH;
				c.cond   = C_ALWAYS;
				c.target = U_TEST;
			end
			U_DONE: begin
				c.cond   = C_OUT_BUSY;
				c.target = U_DONE;
			end
			U_CLR: begin
				c.emit   = 1'b1;
				c.cond   = C_ALWAYS;
				c.target = U_IDLE;
			end
			default: begin
				c.cond   = C_ALWAYS;
				c.target = U_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

// ----- design/huffman_letter_code_length.sv -----
// huffman_letter_code_length: letter histogram and huffman code length per message
//
// input channel s_*: one message byte per beat. letters 'A'..'Z' and 'a'..'z' are
// counted in NUM_SYMBOLS bins, other bytes are dropped, and bytes past MAX_LENGTH
// in one message are dropped too. a newline byte closes the message.
// output channel m_*: one beat per newline carrying the total huffman code length
// in bits (sum of all merged weights, saturating at 65535; zero or one letter kind
// gives 0).
// letters are taken one per cycle; a bin increment reads the count memory into a
// read register and writes back, with a bypass for repeated letters. after a newline,
// s_tready drops while a microcoded sequencer merges the bins: it gathers the nonzero
// bins, then runs two min-scans of the weight memory per merge, until the result
// beat is loaded. the scans read one entry at a time through the single read port
// of the weight memory.
// the result sits in an output register; while the receiver stalls with a result
// still waiting, a new result waits in the sequencer and input stays blocked.
// reset clears the bins (valid bits), the byte count and the output valid bit.
module huffman_letter_code_length #(
	parameter int MAX_LENGTH  = 1024,
	parameter int NUM_SYMBOLS = 52
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [hlcl_pkg::IN_W-1:0]  s_tdata,  // [7:0] message_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [hlcl_pkg::OUT_W-1:0] m_tdata   // [15:0] total_bits
);
	import hlcl_pkg::*;

	localparam int CW = $clog2(MAX_LENGTH + 1);   // counts and weights
	localparam int IW = $clog2(NUM_SYMBOLS);      // bin / weight address
	localparam int LW = $clog2(NUM_SYMBOLS + 1);  // list length

	// sequencer
	step_t pc_q;
	step_t pc_d;
	ctrl_t uc;
	logic  jump;

	// counting front end
	logic [CW-1:0]          bytes_q;
	logic [NUM_SYMBOLS-1:0] cnt_vld_q;
	logic                   v_s1;
	logic                   fwd_s1;
	logic [IW-1:0]          idx_s1;
	logic [CW-1:0]          wval_q;
	logic [ALPHA_W-1:0]     in_idx;
	logic                   is_upper;
	logic                   is_lower;
	logic                   letter_ok;
	logic                   in_acc;
	logic                   go;
	logic                   take;
	logic [CW-1:0]          cnt_base;
	logic [CW-1:0]          cnt_inc;

	// count memory
	logic [CW-1:0] cnt_mem [NUM_SYMBOLS];
	logic [IW-1:0] cnt_raddr;
	logic [CW-1:0] cnt_rd_q;
	logic          cnt_rdv_q;
	logic [CW-1:0] cnt_eff;

	// weight memory
	logic [CW-1:0] mw_mem [NUM_SYMBOLS];
	logic [IW-1:0] mw_raddr;
	logic [CW-1:0] mw_rd_q;
	logic          mw_we;
	logic [IW-1:0] mw_waddr;
	logic [CW-1:0] mw_wdata;

	// merge datapath
	logic [IW-1:0]    gi_q;
	logic [LW-1:0]    si_q;
	logic [LW-1:0]    len_q;
	logic             pick_q;
	logic [CW-1:0]    best_v_q;
	logic [IW-1:0]    best_i_q;
	logic [CW-1:0]    a_q;
	logic [OUT_W-1:0] total_q;
	logic [CW:0]      psum;
	logic [OUT_W:0]   tsum;
	logic [LW-1:0]    len_m1;
	logic [LW-1:0]    si_p1;

	// output register
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	assign uc       = ucode(pc_q);
	assign s_tready = (pc_q == U_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// letter decode
	assign is_upper  = (s_tdata >= CHAR_UPPER_A) && (s_tdata <= CHAR_UPPER_Z);
	assign is_lower  = (s_tdata >= CHAR_LOWER_A) && (s_tdata <= CHAR_LOWER_Z);
	assign in_idx    = is_upper ? (ALPHA_W'(s_tdata - CHAR_UPPER_A) + UPPER_BASE)
	                            : (ALPHA_W'(s_tdata - CHAR_LOWER_A) + LOWER_BASE);
	assign letter_ok = (is_upper || is_lower) && (in_idx < ALPHA_W'(NUM_SYMBOLS));
	assign in_acc    = s_tvalid && s_tready;
	assign go        = in_acc && (s_tdata == NEWLINE_BYTE);
	assign take      = in_acc && (s_tdata != NEWLINE_BYTE) && (bytes_q < CW'(MAX_LENGTH));

	// bin increment with bypass of the write in flight
	assign cnt_eff  = cnt_rdv_q ? cnt_rd_q : '0;
	assign cnt_base = fwd_s1 ? wval_q : cnt_eff;
	assign cnt_inc  = cnt_base + 1'b1;

	assign cnt_raddr = (uc.rd == RD_CNT) ? gi_q : (letter_ok ? in_idx[IW-1:0] : '0);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			cnt_mem[idx_s1] <= cnt_inc;
		end
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	// weight memory ports
	assign len_m1   = len_q - 1'b1;
	assign si_p1    = si_q + 1'b1;
	assign mw_raddr = (uc.rd == RD_MW_LAST) ? len_m1[IW-1:0] : si_q[IW-1:0];
	assign psum     = {1'b0, a_q} + {1'b0, best_v_q};

	always_comb begin
		mw_we    = 1'b0;
		mw_waddr = len_q[IW-1:0];
		mw_wdata = cnt_eff;
		case (uc.wr)
			WR_GATHER: begin
				mw_we = (cnt_eff != '0);
			end
			WR_BEST: begin
				mw_we    = 1'b1;
				mw_waddr = best_i_q;
				mw_wdata = mw_rd_q;
			end
			WR_PUSH: begin
				mw_we    = 1'b1;
				mw_wdata = psum[CW-1:0];
			end
			default: begin
				mw_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mw_we) begin
			mw_mem[mw_waddr] <= mw_wdata;
		end
		mw_rd_q <= mw_mem[mw_raddr];
	end

	// next step
	always_comb begin
		case (uc.cond)
			C_NEXT:       jump = 1'b0;
			C_ALWAYS:     jump = 1'b1;
			C_NOT_GO:     jump = !go;
			C_GI_MORE:    jump = (gi_q != IW'(NUM_SYMBOLS - 1));
			C_LEN_LE1:    jump = (len_q <= LW'(1));
			C_SI_MORE:    jump = (si_p1 != len_q);
			C_PICK_FIRST: jump = !pick_q;
			C_OUT_BUSY:   jump = m_tvalid_q;
			default:      jump = 1'b1;
		endcase
		pc_d = jump ? uc.target : step_t'(pc_q + 1'b1);
	end

	assign tsum = {1'b0, total_q} + (OUT_W + 1)'(psum);

	// sequencer, counters and handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= U_IDLE;
			v_s1       <= 1'b0;
			bytes_q    <= '0;
			cnt_vld_q  <= '0;
			gi_q       <= '0;
			si_q       <= '0;
			len_q      <= '0;
			pick_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			v_s1 <= take && letter_ok;
			if (take) begin
				bytes_q <= bytes_q + 1'b1;
			end
			if (v_s1) begin
				cnt_vld_q[idx_s1] <= 1'b1;
			end
			if (uc.init) begin
				gi_q   <= '0;
				len_q  <= '0;
				pick_q <= 1'b0;
			end
			if (uc.si_clr) begin
				si_q <= '0;
			end
			if (uc.scan) begin
				si_q <= si_p1;
			end
			case (uc.wr)
				WR_GATHER: begin
					gi_q <= gi_q + 1'b1;
					if (cnt_eff != '0) begin
						len_q <= len_q + 1'b1;
					end
				end
				WR_BEST: begin
					len_q  <= len_m1;
					pick_q <= 1'b1;
				end
				WR_PUSH: begin
					len_q  <= len_q + 1'b1;
					pick_q <= 1'b0;
				end
				default: begin
				end
			endcase
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (uc.emit) begin
				m_tvalid_q <= 1'b1;
				cnt_vld_q  <= '0;
				bytes_q    <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cnt_rdv_q <= cnt_vld_q[cnt_raddr];
		if (take && letter_ok) begin
			idx_s1 <= in_idx[IW-1:0];
			fwd_s1 <= v_s1 && (idx_s1 == in_idx[IW-1:0]);
		end
		if (v_s1) begin
			wval_q <= cnt_inc;
		end
		if (uc.init) begin
			total_q <= '0;
		end
		if (uc.scan && ((si_q == '0) || (mw_rd_q < best_v_q))) begin
			best_v_q <= mw_rd_q;
			best_i_q <= si_q[IW-1:0];
		end
		if ((uc.wr == WR_BEST) && !pick_q) begin
			a_q <= best_v_q;
		end
		if (uc.wr == WR_PUSH) begin
			total_q <= tsum[OUT_W] ? TOTAL_MAX : tsum[OUT_W-1:0];
		end
		if (uc.emit) begin
			m_tdata_q <= total_q;
		end
	end

endmodule

// ----- design/hlcl_checker.sv -----
module hlcl_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [hlcl_pkg::IN_W-1:0]  s_tdata,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [hlcl_pkg::OUT_W-1:0] m_tdata
);
	import hlcl_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// a newline starts the merge, input closes
	a_newline_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata == NEWLINE_BYTE) |=> !s_tready)
		else $error("input still open after newline");

	// other bytes never stall the input
	a_byte_open: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata != NEWLINE_BYTE) |=> s_tready)
		else $error("input closed after a non-newline byte");

	// a result only appears at the end of a merge
	a_result_after_merge: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result beat without a merge");

endmodule

bind huffman_letter_code_length hlcl_checker u_hlcl_checker (.*);

// ----- sim/tb.sv -----
module tb;
	import hlcl_pkg::*;

	// block configuration, kept equal to the defaults of the block
	localparam int MAX_LENGTH  = 1024;
	localparam int NUM_SYMBOLS = 52;
	localparam int ALPHA_HALF  = 26;

	// cycles with no beat on either side before the run is declared hung
	localparam int QUIET_LIMIT = 50000;
	// cycles to watch for a stray result beat once everything has arrived
	localparam int DRAIN_CYCLES = 6500;
	// rough number of bytes per idling phase
	localparam int PHASE_BYTES = 125;

	// one row of the directed table: a byte and, on a newline, an optional
	// typed-in code length that replaces the predicted one
	typedef struct packed {
		logic [IN_W-1:0]  msg_byte;
		logic             typed;
		logic [OUT_W-1:0] total;
	} stim_row_t;

	localparam int N_ROWS = 25;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;   // [7:0] message_byte
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;        // [15:0] total_bits

	// predictor state: letter histogram and bytes taken in the open message
	int letter_tally [NUM_SYMBOLS];
	int taken_cnt;

	// code lengths still owed by the block, oldest first
	logic [OUT_W-1:0] expected_totals [$];
	logic [OUT_W-1:0] want_total;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_cnt = 0;
	int bytes_sent = 0;
	int messages_closed = 0;
	int totals_checked = 0;
	int quiet_cycles = 0;

	stim_row_t directed_rows [N_ROWS] = '{
		// empty message right after reset
		'{NEWLINE_BYTE, 1'b1, 16'd0},
		// a single letter kind
		'{CHAR_UPPER_A, 1'b0, 16'd0},
		'{NEWLINE_BYTE, 1'b1, 16'd0},
		// two kinds, one each: one merge of weight 2
		'{CHAR_UPPER_A, 1'b0, 16'd0},
		'{CHAR_UPPER_A + 8'd1, 1'b0, 16'd0},
		'{NEWLINE_BYTE, 1'b1, 16'd2},
		// last letters of both cases, then extreme bytes and bytes just outside the letter ranges
		'{CHAR_LOWER_Z, 1'b0, 16'd0},
		'{CHAR_UPPER_Z, 1'b0, 16'd0},
		'{8'h00, 1'b0, 16'd0},
		'{8'hFF, 1'b0, 16'd0},
		'{CHAR_UPPER_A - 8'd1, 1'b0, 16'd0},
		'{CHAR_UPPER_Z + 8'd1, 1'b0, 16'd0},
		'{CHAR_LOWER_A - 8'd1, 1'b0, 16'd0},
		'{CHAR_LOWER_Z + 8'd1, 1'b0, 16'd0},
		'{NEWLINE_BYTE, 1'b1, 16'd2},
		// weights 2 and 1: one merge of weight 3
		'{CHAR_LOWER_A, 1'b0, 16'd0},
		'{CHAR_LOWER_A, 1'b0, 16'd0},
		'{CHAR_LOWER_A + 8'd1, 1'b0, 16'd0},
		'{NEWLINE_BYTE, 1'b1, 16'd3},
		// neighbors of the newline code, same letter in both cases
		'{NEWLINE_BYTE + 8'd1, 1'b0, 16'd0},
		'{NEWLINE_BYTE - 8'd1, 1'b0, 16'd0},
		'{CHAR_UPPER_A + 8'd12, 1'b0, 16'd0},
		'{CHAR_LOWER_A + 8'd12, 1'b0, 16'd0},
		'{CHAR_LOWER_A + 8'd12, 1'b0, 16'd0},
		'{NEWLINE_BYTE, 1'b0, 16'd0}
	};

	huffman_letter_code_length #(
		.MAX_LENGTH (MAX_LENGTH),
		.NUM_SYMBOLS(NUM_SYMBOLS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// sum of all merged weights over the nonzero bins, saturating at 16 bits
	function automatic logic [OUT_W-1:0] code_length_total();
		int w [NUM_SYMBOLS];
		int pick [2];
		int n;
		int best;
		int total;
		n = 0;
		total = 0;
		for (int i = 0; i < NUM_SYMBOLS; i++) begin
			if (letter_tally[i] != 0) begin
				w[n] = letter_tally[i];
				n++;
			end
		end
		while (n > 1) begin
			// pull out the two smallest, last entry fills the hole
			for (int k = 0; k < 2; k++) begin
				best = 0;
				for (int i = 1; i < n; i++) begin
					if (w[i] < w[best])
						best = i;
				end
				pick[k] = w[best];
				w[best] = w[n-1];
				n--;
			end
			w[n] = pick[0] + pick[1];
			n++;
			total += pick[0] + pick[1];
			if (total > int'(TOTAL_MAX))
				total = int'(TOTAL_MAX);
		end
		return total[OUT_W-1:0];
	endfunction

	// advance the predictor by one accepted byte; returns 1 when it closes a message
	function automatic logic tally_byte(input logic [IN_W-1:0] b, output logic [OUT_W-1:0] total);
		int bin;
		total = '0;
		if (b == NEWLINE_BYTE) begin
			total = code_length_total();
			foreach (letter_tally[i])
				letter_tally[i] = 0;
			taken_cnt = 0;
			return 1'b1;
		end
		// bytes past the length cap are dropped, letters or not
		if (taken_cnt >= MAX_LENGTH)
			return 1'b0;
		taken_cnt++;
		bin = -1;
		if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
			bin = int'(UPPER_BASE) + int'(b - CHAR_UPPER_A);
		else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z)
			bin = int'(LOWER_BASE) + int'(b - CHAR_LOWER_A);
		if (bin >= 0 && bin < NUM_SYMBOLS)
			letter_tally[bin]++;
		return 1'b0;
	endfunction

	function automatic logic [IN_W-1:0] bin_letter(input int bin);
		if (bin < ALPHA_HALF)
			return CHAR_UPPER_A + IN_W'(bin);
		return CHAR_LOWER_A + IN_W'(bin - ALPHA_HALF);
	endfunction

	task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		$display("mismatch @%0t: %s, got %0d expected %0d", $time, what, got, want);
		mismatch_cnt++;
	endtask

	// offer one byte, honoring the sender idle rate, and book its result on acceptance
	task automatic push_byte(input logic [IN_W-1:0] b, input logic typed,
			input logic [OUT_W-1:0] typed_total);
		logic [OUT_W-1:0] predicted;
		logic closes;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		closes = tally_byte(b, predicted);
		bytes_sent++;
		if (closes) begin
			messages_closed++;
			expected_totals.push_back(typed ? typed_total : predicted);
		end
	endtask

	// hold the input channel quiet until every owed code length has come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_totals.size() != 0)
			@(posedge clk);
	endtask

	// one message with random content and a closing newline
	// full_set: every bin once first, so the merge runs over all 52 weights
	task automatic send_message(input logic full_set, output int n_bytes);
		int kinds [8];
		int n_kinds;
		int len;
		int r;
		logic [IN_W-1:0] b;
		n_kinds = $urandom_range(1, 8);
		foreach (kinds[i])
			kinds[i] = $urandom_range(0, NUM_SYMBOLS - 1);
		len = full_set ? $urandom_range(NUM_SYMBOLS, 2 * NUM_SYMBOLS) : $urandom_range(0, 16);
		for (int k = 0; k < len; k++) begin
			r = $urandom_range(99);
			if (full_set && k < NUM_SYMBOLS)
				b = bin_letter(k);
			else if (r < 75)
				b = bin_letter(kinds[$urandom_range(0, n_kinds - 1)]);
			else if (r < 90)
				// noise, a stray newline here cuts the message short
				b = IN_W'($urandom_range(0, 255));
			else begin
				case ($urandom_range(0, 3))
					0: b = CHAR_UPPER_A - 8'd1;
					1: b = CHAR_UPPER_Z + 8'd1;
					2: b = CHAR_LOWER_A - 8'd1;
					default: b = CHAR_LOWER_Z + 8'd1;
				endcase
			end
			push_byte(b, 1'b0, '0);
		end
		push_byte(NEWLINE_BYTE, 1'b0, '0);
		n_bytes = len + 1;
	endtask

	// receiver: random stalls at the current rate
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// result checker: every accepted beat against the oldest owed code length
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_totals.size() == 0) begin
				report_mismatch("result beat with nothing owed", m_tdata, '0);
			end else begin
				want_total = expected_totals.pop_front();
				totals_checked++;
				if (m_tdata !== want_total)
					report_mismatch("total_bits", m_tdata, want_total);
			end
		end
	end

	// watchdog: a long run of cycles with no beat on either side means a hang
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results still owed",
				quiet_cycles, expected_totals.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int phase_bytes;
		int n_bytes;

		foreach (letter_tally[i])
			letter_tally[i] = 0;
		taken_cnt = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		foreach (directed_rows[i])
			push_byte(directed_rows[i].msg_byte, directed_rows[i].typed,
				directed_rows[i].total);

		// length cap: 1024 random letters, then a tail of letters that must be dropped
		for (int k = 0; k < MAX_LENGTH; k++)
			push_byte(bin_letter($urandom_range(0, NUM_SYMBOLS - 1)), 1'b0, '0);
		for (int k = 0; k < 8; k++)
			push_byte(bin_letter($urandom_range(0, NUM_SYMBOLS - 1)), 1'b0, '0);
		push_byte(NEWLINE_BYTE, 1'b0, '0);

		// worst case merge over all bins
		send_message(1'b1, n_bytes);
		drain_results();

		// random messages under four idling mixes, pausing for all results in between
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 79;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 79;
				end
				default: begin
					send_idle_pct  = 22;
					recv_stall_pct = 22;
				end
			endcase
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				send_message($urandom_range(99) < 4, n_bytes);
				phase_bytes += n_bytes;
			end
			drain_results();
		end

		// look for stray result beats after the last owed one
		s_tvalid <= 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes in %0d messages, incl. the length cap and a full 52-bin merge",
			bytes_sent, messages_closed);
		$display("checked %0d code lengths over four idle/stall mixes, %0d mismatches",
			totals_checked, mismatch_cnt);
		if (mismatch_cnt == 0 && expected_totals.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
